>>> rtl/unsigned_to_ascii_radix_top_macros.svh
// Assertion macros shared by the RTL of the radix-to-ASCII converter.
`ifndef UNSIGNED_TO_ASCII_RADIX_TOP_MACROS_SVH
`define UNSIGNED_TO_ASCII_RADIX_TOP_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define U2A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset.
`define U2A_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/u2a_pkg.sv
// Types, constants and the digit-to-ASCII map of the radix converter.
package u2a_pkg;

  localparam int OpW    = 2;
  localparam int CharW  = 7;
  localparam int CountW = 4;

  localparam logic [CharW-1:0] AsciiZero   = 7'd48;
  localparam logic [CharW-1:0] AsciiLowerA = 7'd97;
  localparam logic [CharW-1:0] AsciiUpperA = 7'd65;
  localparam logic [3:0]       DigitTen    = 4'd10;

  typedef enum logic [OpW-1:0] {
    OpDec      = 2'd0,
    OpOct      = 2'd1,
    OpHexLower = 2'd2,
    OpHexUpper = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  function automatic logic [CharW-1:0] u2a_ascii(logic [3:0] digit, logic upper);
    logic [CharW-1:0] res;
    if (digit < DigitTen) begin
      res = AsciiZero + CharW'(digit);
    end else if (upper) begin
      res = AsciiUpperA + CharW'(digit - DigitTen);
    end else begin
      res = AsciiLowerA + CharW'(digit - DigitTen);
    end
    return res;
  endfunction

endpackage

>>> rtl/u2a_if.sv
// Valid/ready channel interfaces: number beats in, character beats out.
interface u2a_in_if import u2a_pkg::*; #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [OpW-1:0]        operation;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface u2a_out_if import u2a_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CharW-1:0]  character;
  logic              last;
  logic [CountW-1:0] digit_count;

  modport source (output valid, output character, output last, output digit_count,
                  input ready);
  modport sink   (input valid, input character, input last, input digit_count,
                  output ready);
endinterface

>>> rtl/u2a_dabble.sv
// One double-dabble step: add-3 correction per BCD digit, then shift in a bit.
module u2a_dabble #(
  parameter int DIGITS = 10
) (
  input  logic [DIGITS*4-1:0] bcd_i,
  input  logic                bit_i,
  output logic [DIGITS*4-1:0] bcd_o
);

  logic [DIGITS*4-1:0] adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_i[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[DIGITS*4-2:0], bit_i};

endmodule

>>> rtl/unsigned_to_ascii_radix_top.sv
// Top level: unsigned number to ASCII text in decimal, octal or hex.
//
//  channel  dir  payload                              beat
//  in_i     in   operation, value                     one number
//  out_o    out  character, last, digit_count         one character, MS digit first
//
// Decimal: bit-serial double dabble over all VALUE_BITS input bits (32 by default).
// Then leading zero digits are dropped one at a time, emission starts,
// and the characters go out one by one while out_o is ready.
// Octal and hex skip the conversion and start at the leading-zero scan.
// A new number is taken once the last character sits in the output register.
// Reset clears the control state only; out_o stalls hold the character in place.
module unsigned_to_ascii_radix_top import u2a_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2a_in_if.sink    in_i,
  u2a_out_if.source out_o
);

  `include "unsigned_to_ascii_radix_top_macros.svh"

  localparam int NumSlots  = (VALUE_BITS + 2) / 3;
  localparam int HexDigits = (VALUE_BITS + 3) / 4;
  localparam int DecDigits = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int SlotBits  = NumSlots * 4;
  localparam int HexBits   = HexDigits * 4;
  localparam int DecBits   = DecDigits * 4;
  localparam int CntW      = $clog2(NumSlots + 1);
  localparam int BitCntW   = $clog2(VALUE_BITS);

  state_e                state_q, state_d;
  logic [SlotBits-1:0]   digs_q, digs_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BitCntW-1:0]    bcnt_q, bcnt_d;
  logic [CntW-1:0]       rem_q, rem_d;
  logic [CntW-1:0]       tot_q, tot_d;
  logic                  upper_q, upper_d;

  logic                  ov_q, ov_d;
  logic [CharW-1:0]      char_q;
  logic                  last_q;
  logic [CountW-1:0]     cnt_q;

  logic [NumSlots*3-1:0] oct_pad;
  logic [SlotBits-1:0]   oct_slots;
  logic [SlotBits-1:0]   hex_slots;
  logic [DecBits-1:0]    bcd_next;
  logic [3:0]            top_digit;
  logic                  in_fire;
  logic                  out_load;

  assign in_fire   = in_i.valid && in_i.ready;
  assign top_digit = digs_q[SlotBits-1 -: 4];
  assign out_load  = (state_q == StEmit) && (!ov_q || out_o.ready);

  assign oct_pad   = (NumSlots*3)'(in_i.value);
  assign hex_slots = SlotBits'(in_i.value) << (SlotBits - HexBits);

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      oct_slots[i*4 +: 4] = {1'b0, oct_pad[i*3 +: 3]};
    end
  end

  u2a_dabble #(
    .DIGITS (DecDigits)
  ) u_dabble (
    .bcd_i (digs_q[SlotBits-1 -: DecBits]),
    .bit_i (bin_q[VALUE_BITS-1]),
    .bcd_o (bcd_next)
  );

  always_comb begin
    state_d = state_q;
    digs_d  = digs_q;
    bin_d   = bin_q;
    bcnt_d  = bcnt_q;
    rem_d   = rem_q;
    tot_d   = tot_q;
    upper_d = upper_q;
    ov_d    = ov_q;
    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          upper_d = (op_e'(in_i.operation) == OpHexUpper);
          case (op_e'(in_i.operation))
            OpDec: begin
              digs_d  = '0;
              bin_d   = in_i.value;
              bcnt_d  = BitCntW'(VALUE_BITS - 1);
              rem_d   = CntW'(DecDigits);
              state_d = StConv;
            end
            OpOct: begin
              digs_d  = oct_slots;
              rem_d   = CntW'(NumSlots);
              state_d = StSkip;
            end
            default: begin
              digs_d  = hex_slots;
              rem_d   = CntW'(HexDigits);
              state_d = StSkip;
            end
          endcase
        end
      end
      StConv: begin
        digs_d[SlotBits-1 -: DecBits] = bcd_next;
        bin_d = bin_q << 1;
        if (bcnt_q == '0) begin
          state_d = StSkip;
        end else begin
          bcnt_d = bcnt_q - 1'b1;
        end
      end
      StSkip: begin
        if (top_digit == 4'd0 && rem_q != CntW'(1)) begin
          digs_d = digs_q << 4;
          rem_d  = rem_q - 1'b1;
        end else begin
          tot_d   = rem_q;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          ov_d   = 1'b1;
          digs_d = digs_q << 4;
          rem_d  = rem_q - 1'b1;
          if (rem_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q  <= digs_d;
    bin_q   <= bin_d;
    bcnt_q  <= bcnt_d;
    rem_q   <= rem_d;
    tot_q   <= tot_d;
    upper_q <= upper_d;
    if (out_load) begin
      char_q <= u2a_ascii(top_digit, upper_q);
      last_q <= (rem_q == CntW'(1));
      cnt_q  <= (rem_q == CntW'(1)) ? CountW'(tot_q) : '0;
    end
  end

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = ov_q;
  assign out_o.character   = char_q;
  assign out_o.last        = last_q;
  assign out_o.digit_count = cnt_q;

  `U2A_ASSERT(a_count_only_on_last, ov_q && !last_q |-> cnt_q == '0, "count off last beat")
  `U2A_ASSERT(a_accept_starts_work, in_fire |=> state_q == StConv || state_q == StSkip,
    "accepted number not started")
  `U2A_ASSERT(a_rem_nonzero, state_q == StSkip || state_q == StEmit |-> rem_q != '0,
    "digit counter ran out")
  `U2A_ASSERT_ALWAYS(a_ready_idle, in_i.ready |-> state_q == StIdle, "ready outside idle")

endmodule
